// ===== sv/assert_macros.svh =====
// Assertion macros used by the port-level checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on an explicit clock and active-low reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Concurrent assertion on the block clock aclk and reset aresetn.
`define ASSERT_ACLK(label, prop, msg) \
    `ASSERT_CLK(label, aclk, aresetn, prop, msg)

`endif

// ===== sv/mvc_pkg.sv =====
// Package for the multichannel valid convolution: codes, widths, control types.
`default_nettype none

package mvc_pkg;

    localparam int OP_W      = 2;
    localparam int CHANNEL_W = 2;
    localparam int ROW_W     = 6;
    localparam int COL_W     = 6;
    localparam int VALUE_W   = 16;
    localparam int OUT_W     = 40;

    localparam int S_TDATA_W = 32;
    localparam int M_TDATA_W = 40;

    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 7;

    localparam logic [OP_W-1:0] OP_WRITE_KERNEL = 2'd0;
    localparam logic [OP_W-1:0] OP_WRITE_IMAGE  = 2'd1;
    localparam logic [OP_W-1:0] OP_COMPUTE      = 2'd2;

    localparam logic [CFG_ADDR_W-1:0] CFG_IMAGE_WIDTH   = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_IMAGE_HEIGHT  = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_KERNEL_WIDTH  = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_KERNEL_HEIGHT = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_CHANNEL_COUNT = 3'd4;

    typedef struct packed {
        logic wr_kernel;
        logic wr_image;
        logic start;
        logic issue;
        logic load_result;
    } cmd_t;

    typedef struct packed {
        logic oor_in;
        logic last_tap;
        logic pipe_busy;
    } status_t;

endpackage

`default_nettype wire

// ===== sv/mvc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module mvc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== sv/mvc_ctrl.sv =====
// Controller state machine: input and result handshakes, compute sequencing.
`default_nettype none

module mvc_ctrl (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     s_tvalid,
    output logic                          s_tready,
    input  wire logic [mvc_pkg::OP_W-1:0] op,
    output logic                          m_tvalid,
    input  wire logic                     m_tready,
    output mvc_pkg::cmd_t                 cmd,
    input  wire mvc_pkg::status_t         status
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN,
        ST_FINISH
    } state_t;

    state_t state_reg, state_next;
    logic   m_tvalid_reg, m_tvalid_next;

    always_comb begin
        state_next    = state_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        cmd           = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    unique case (op)
                        mvc_pkg::OP_WRITE_KERNEL: cmd.wr_kernel = 1'b1;
                        mvc_pkg::OP_WRITE_IMAGE:  cmd.wr_image  = 1'b1;
                        mvc_pkg::OP_COMPUTE: begin
                            cmd.start  = 1'b1;
                            state_next = status.oor_in ? ST_FINISH : ST_RUN;
                        end
                        default: ;
                    endcase
                end
            end
            ST_RUN: begin
                cmd.issue = 1'b1;
                if (status.last_tap) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!status.pipe_busy) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (!m_tvalid_reg || m_tready) begin
                    cmd.load_result = 1'b1;
                    m_tvalid_next   = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;

endmodule

`default_nettype wire

// ===== sv/mvc_datapath.sv =====
// Datapath: size registers, image and kernel stores, tap counters, MAC pipeline.
`default_nettype none

module mvc_datapath #(
    parameter int MAX_WIDTH    = 64,
    parameter int MAX_HEIGHT   = 64,
    parameter int MAX_KERNEL   = 8,
    parameter int MAX_CHANNELS = 4
) (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    input  wire logic                                  cfg_valid,
    input  wire logic        [mvc_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic        [mvc_pkg::CFG_DATA_W-1:0] cfg_data,
    input  wire logic        [mvc_pkg::CHANNEL_W-1:0]  in_channel,
    input  wire logic        [mvc_pkg::ROW_W-1:0]      in_row,
    input  wire logic        [mvc_pkg::COL_W-1:0]      in_col,
    input  wire logic signed [mvc_pkg::VALUE_W-1:0]    in_sample,
    input  wire mvc_pkg::cmd_t                         cmd,
    output mvc_pkg::status_t                           status,
    output logic signed      [mvc_pkg::OUT_W-1:0]      conv_value,
    output logic                                       result_status
);

    localparam int CHW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int RW  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int XW  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int KBW = (MAX_KERNEL > 1) ? $clog2(MAX_KERNEL) : 1;

    localparam int IMG_AW    = CHW + RW + XW;
    localparam int IMG_DEPTH = 1 << IMG_AW;
    localparam int KER_AW    = CHW + 2 * KBW;
    localparam int KER_DEPTH = 1 << KER_AW;

    localparam int NTAPS   = MAX_CHANNELS * MAX_KERNEL * MAX_KERNEL;
    localparam int SUM_W   = 2 * mvc_pkg::VALUE_W + 1 + $clog2(NTAPS + 1);
    localparam int ACC_W   = (SUM_W > mvc_pkg::OUT_W) ? SUM_W : mvc_pkg::OUT_W;
    localparam int PROD_W  = 2 * mvc_pkg::VALUE_W;

    localparam logic signed [ACC_W-1:0] SAT_MAX =
        signed'({{(ACC_W - mvc_pkg::OUT_W + 1){1'b0}}, {(mvc_pkg::OUT_W - 1){1'b1}}});
    localparam logic signed [ACC_W-1:0] SAT_MIN =
        signed'({{(ACC_W - mvc_pkg::OUT_W + 1){1'b1}}, {(mvc_pkg::OUT_W - 1){1'b0}}});

    function automatic int clamp_size(int v, int hi);
        if (v < 1) begin
            return 1;
        end
        if (v > hi) begin
            return hi;
        end
        return v;
    endfunction

    // Size registers hold the clamped value.
    logic [6:0] iw_reg, ih_reg;
    logic [3:0] kw_reg, kh_reg;
    logic [2:0] cc_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            iw_reg <= 7'(clamp_size(64, MAX_WIDTH));
            ih_reg <= 7'(clamp_size(64, MAX_HEIGHT));
            kw_reg <= 4'(clamp_size(3, MAX_KERNEL));
            kh_reg <= 4'(clamp_size(3, MAX_KERNEL));
            cc_reg <= 3'(clamp_size(1, MAX_CHANNELS));
        end else if (cfg_valid) begin
            unique case (cfg_addr)
                mvc_pkg::CFG_IMAGE_WIDTH:
                    iw_reg <= 7'(clamp_size(int'(cfg_data[6:0]), MAX_WIDTH));
                mvc_pkg::CFG_IMAGE_HEIGHT:
                    ih_reg <= 7'(clamp_size(int'(cfg_data[6:0]), MAX_HEIGHT));
                mvc_pkg::CFG_KERNEL_WIDTH:
                    kw_reg <= 4'(clamp_size(int'(cfg_data[3:0]), MAX_KERNEL));
                mvc_pkg::CFG_KERNEL_HEIGHT:
                    kh_reg <= 4'(clamp_size(int'(cfg_data[3:0]), MAX_KERNEL));
                mvc_pkg::CFG_CHANNEL_COUNT:
                    cc_reg <= 3'(clamp_size(int'(cfg_data[2:0]), MAX_CHANNELS));
                default: ;
            endcase
        end
    end

    // Valid area check on the incoming position; also covers kernel > image.
    logic [7:0] col_end, row_end;
    assign col_end = 8'(in_col) + 8'(kw_reg);
    assign row_end = 8'(in_row) + 8'(kh_reg);

    // Store writes
    logic              ker_we, img_we;
    logic [KER_AW-1:0] ker_waddr, ker_raddr;
    logic [IMG_AW-1:0] img_waddr, img_raddr;
    logic [mvc_pkg::VALUE_W-1:0] ker_rdata, img_rdata;

    assign ker_we = cmd.wr_kernel && (int'(in_channel) < MAX_CHANNELS)
                    && (int'(in_row) < MAX_KERNEL) && (int'(in_col) < MAX_KERNEL);
    assign img_we = cmd.wr_image && (int'(in_channel) < MAX_CHANNELS)
                    && (int'(in_row) < MAX_HEIGHT) && (int'(in_col) < MAX_WIDTH);
    assign ker_waddr = {CHW'(in_channel), KBW'(in_row), KBW'(in_col)};
    assign img_waddr = {CHW'(in_channel), RW'(in_row), XW'(in_col)};

    // Tap counters and latched position
    logic [CHW-1:0] c_reg;
    logic [KBW-1:0] r_reg, k_reg;
    logic [mvc_pkg::ROW_W-1:0] row_reg;
    logic [mvc_pkg::COL_W-1:0] col_reg;
    logic oor_reg;
    logic k_last, r_last, c_last;
    logic [7:0] img_row, img_col;

    assign k_last = (8'(k_reg) == 8'(kw_reg - 4'd1));
    assign r_last = (8'(r_reg) == 8'(kh_reg - 4'd1));
    assign c_last = (8'(c_reg) == 8'(cc_reg - 3'd1));

    assign img_row   = 8'(row_reg) + 8'(r_reg);
    assign img_col   = 8'(col_reg) + 8'(k_reg);
    assign ker_raddr = {c_reg, r_reg, k_reg};
    assign img_raddr = {c_reg, RW'(img_row), XW'(img_col)};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c_reg <= '0;
            r_reg <= '0;
            k_reg <= '0;
        end else if (cmd.start) begin
            c_reg <= '0;
            r_reg <= '0;
            k_reg <= '0;
        end else if (cmd.issue) begin
            if (k_last) begin
                k_reg <= '0;
                if (r_last) begin
                    r_reg <= '0;
                    c_reg <= c_reg + CHW'(1);
                end else begin
                    r_reg <= r_reg + KBW'(1);
                end
            end else begin
                k_reg <= k_reg + KBW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            row_reg <= in_row;
            col_reg <= in_col;
            oor_reg <= status.oor_in;
        end
    end

    mvc_ram #(
        .WIDTH (mvc_pkg::VALUE_W),
        .DEPTH (KER_DEPTH)
    ) u_kernel_ram (
        .aclk  (aclk),
        .we    (ker_we),
        .waddr (ker_waddr),
        .wdata (in_sample),
        .raddr (ker_raddr),
        .rdata (ker_rdata)
    );

    mvc_ram #(
        .WIDTH (mvc_pkg::VALUE_W),
        .DEPTH (IMG_DEPTH)
    ) u_image_ram (
        .aclk  (aclk),
        .we    (img_we),
        .waddr (img_waddr),
        .wdata (in_sample),
        .raddr (img_raddr),
        .rdata (img_rdata)
    );

    // MAC pipeline: read, multiply, accumulate
    logic rd_v_reg, prod_v_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]  acc_reg, sat_acc;
    logic signed [mvc_pkg::OUT_W-1:0] conv_reg;
    logic res_status_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_v_reg   <= 1'b0;
            prod_v_reg <= 1'b0;
        end else begin
            rd_v_reg   <= cmd.issue;
            prod_v_reg <= rd_v_reg;
        end
    end

    always_ff @(posedge aclk) begin
        prod_reg <= $signed(img_rdata) * $signed(ker_rdata);
        if (cmd.start) begin
            acc_reg <= '0;
        end else if (prod_v_reg) begin
            acc_reg <= acc_reg + ACC_W'(prod_reg);
        end
    end

    always_comb begin
        if (acc_reg > SAT_MAX) begin
            sat_acc = SAT_MAX;
        end else if (acc_reg < SAT_MIN) begin
            sat_acc = SAT_MIN;
        end else begin
            sat_acc = acc_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_result) begin
            res_status_reg <= oor_reg;
            conv_reg       <= oor_reg ? '0 : sat_acc[mvc_pkg::OUT_W-1:0];
        end
    end

    assign status.oor_in    = (col_end > 8'(iw_reg)) || (row_end > 8'(ih_reg));
    assign status.last_tap  = k_last && r_last && c_last;
    assign status.pipe_busy = rd_v_reg || prod_v_reg;

    assign conv_value    = conv_reg;
    assign result_status = res_status_reg;

endmodule

`default_nettype wire

// ===== sv/multichannel_valid_convolution.sv =====
// Top level of the multichannel valid convolution block.
//
// Write items fill the kernel and image stores, and the input stays ready
// after each one. A compute item walks channel_count x kernel_height x
// kernel_width taps through one multiply-accumulate unit, one tap per cycle,
// fed by one read port on each store; the input takes no new transfer until
// the taps are issued, the pipeline drains and the result is loaded into the
// output register. A position outside the valid output area skips the taps
// and returns status 1 and zero. A finished result waits in an output register
// while the next item is taken. Stores are not cleared at reset; read entries
// must be written first.
`default_nettype none

module multichannel_valid_convolution #(
    parameter int MAX_WIDTH    = 64,
    parameter int MAX_HEIGHT   = 64,
    parameter int MAX_KERNEL   = 8,
    parameter int MAX_CHANNELS = 4
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    // channel[1:0], row[7:2], col[13:8], value[29:14], zero[31:30]
    input  wire logic [mvc_pkg::S_TDATA_W-1:0]  s_tdata,
    // operation[1:0]
    input  wire logic [mvc_pkg::OP_W-1:0]       s_tuser,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    // conv_value[39:0]
    output logic      [mvc_pkg::M_TDATA_W-1:0]  m_tdata,
    // status[0]
    output logic      [0:0]                     m_tuser,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [mvc_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [mvc_pkg::CFG_DATA_W-1:0] cfg_data
);

    mvc_pkg::cmd_t    cmd;
    mvc_pkg::status_t status;
    logic signed [mvc_pkg::OUT_W-1:0] conv_value;
    logic result_status;

    assign cfg_ready = 1'b1;

    mvc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .op       (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .status   (status)
    );

    mvc_datapath #(
        .MAX_WIDTH    (MAX_WIDTH),
        .MAX_HEIGHT   (MAX_HEIGHT),
        .MAX_KERNEL   (MAX_KERNEL),
        .MAX_CHANNELS (MAX_CHANNELS)
    ) u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_valid     (cfg_valid),
        .cfg_addr      (cfg_addr),
        .cfg_data      (cfg_data),
        .in_channel    (s_tdata[1:0]),
        .in_row        (s_tdata[7:2]),
        .in_col        (s_tdata[13:8]),
        .in_sample     (s_tdata[29:14]),
        .cmd           (cmd),
        .status        (status),
        .conv_value    (conv_value),
        .result_status (result_status)
    );

    assign m_tdata    = conv_value;
    assign m_tuser[0] = result_status;

endmodule

`default_nettype wire

// ===== sv/mvc_checker.sv =====
// Port-level checker for the multichannel valid convolution, with its bind.
`default_nettype none
`include "assert_macros.svh"

module mvc_checker (
    input wire logic                           aclk,
    input wire logic                           aresetn,
    input wire logic                           s_tvalid,
    input wire logic                           s_tready,
    input wire logic [mvc_pkg::OP_W-1:0]       s_tuser,
    input wire logic                           m_tvalid,
    input wire logic                           m_tready,
    input wire logic [mvc_pkg::M_TDATA_W-1:0]  m_tdata,
    input wire logic [0:0]                     m_tuser
);

    logic s_xfer;
    assign s_xfer = s_tvalid && s_tready;

    `ASSERT_ACLK(a_result_held, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result changed while stalled")
    `ASSERT_ACLK(a_oor_zero, m_tvalid && m_tuser[0] |-> m_tdata == '0, "out-of-range result not zero")
    `ASSERT_ACLK(a_write_no_result, s_xfer && (s_tuser != mvc_pkg::OP_COMPUTE) && !m_tvalid |=> !m_tvalid, "write transfer produced a result")
    `ASSERT_ACLK(a_compute_busy, s_xfer && (s_tuser == mvc_pkg::OP_COMPUTE) |=> !s_tready, "input ready during compute")

endmodule

bind multichannel_valid_convolution mvc_checker u_mvc_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
);

`default_nettype wire

// ===== bench/multichannel_valid_convolution_test.sv =====
// Stream testbench for the multichannel valid convolution: directed corners, then random traffic.
module multichannel_valid_convolution_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_W  = 64;
    localparam int MAX_H  = 64;
    localparam int MAX_K  = 8;
    localparam int MAX_CH = 4;
    localparam int SETTLE_CYCLES = MAX_CH * MAX_K * MAX_K + 40;
    localparam int QUIET_LIMIT   = 4000;
    localparam longint SUM_MAX   = 64'sd549755813887;
    localparam longint SUM_MIN   = -SUM_MAX - 1;
    localparam logic [mvc_pkg::OP_W-1:0] OP_UNUSED = 2'd3;

    typedef logic [mvc_pkg::VALUE_W-1:0] sample_t;
    typedef logic [mvc_pkg::OUT_W-1:0]   out_word_t;

    typedef struct packed {
        logic [mvc_pkg::OP_W-1:0]           op;
        logic [mvc_pkg::CHANNEL_W-1:0]      channel;
        logic [mvc_pkg::ROW_W-1:0]          row;
        logic [mvc_pkg::COL_W-1:0]          col;
        logic signed [mvc_pkg::VALUE_W-1:0] value;
    } conv_item_t;

    typedef struct packed {
        logic signed [mvc_pkg::OUT_W-1:0] conv_value;
        logic                             status;
    } conv_result_t;

    logic                           aclk      = 1'b0;
    logic                           aresetn   = 1'b0;
    logic                           s_tvalid  = 1'b0;
    logic                           s_tready;
    logic [mvc_pkg::S_TDATA_W-1:0]  s_tdata   = '0;
    logic [mvc_pkg::OP_W-1:0]       s_tuser   = '0;
    logic                           m_tvalid;
    logic                           m_tready  = 1'b0;
    logic [mvc_pkg::M_TDATA_W-1:0]  m_tdata;
    logic [0:0]                     m_tuser;
    logic                           cfg_valid = 1'b0;
    logic                           cfg_ready;
    logic [mvc_pkg::CFG_ADDR_W-1:0] cfg_addr  = '0;
    logic [mvc_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

    // predictor state
    logic signed [mvc_pkg::VALUE_W-1:0] image_mem  [MAX_CH][MAX_H][MAX_W];
    bit                                 image_set  [MAX_CH][MAX_H][MAX_W];
    logic signed [mvc_pkg::VALUE_W-1:0] kernel_mem [MAX_CH][MAX_K][MAX_K];
    bit                                 kernel_set [MAX_CH][MAX_K][MAX_K];
    logic [6:0] width_reg   = 7'd64;
    logic [6:0] height_reg  = 7'd64;
    logic [3:0] kwidth_reg  = 4'd3;
    logic [3:0] kheight_reg = 4'd3;
    logic [2:0] chan_reg    = 3'd1;

    conv_result_t pending_sums[$];

    int send_idle_pct = 14;
    int recv_idle_pct = 46;
    int stall_request = 0;
    int stall_left    = 0;
    int quiet_cycles  = 0;
    int error_count   = 0;
    int counted_items = 0;
    int compute_count = 0;
    int oob_count     = 0;
    int write_count   = 0;
    int cfg_count     = 0;

    multichannel_valid_convolution i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_addr  (cfg_addr),
        .cfg_data  (cfg_data)
    );

    initial begin
        forever #10 aclk = ~aclk;
    end

    function automatic int unsigned clamp_dim(input int unsigned v, input int unsigned hi);
        return (v < 1) ? 1 : ((v > hi) ? hi : v);
    endfunction

    function automatic bit in_valid_area(input int unsigned row, input int unsigned col);
        int unsigned iw = clamp_dim(32'(width_reg), MAX_W);
        int unsigned ih = clamp_dim(32'(height_reg), MAX_H);
        int unsigned kw = clamp_dim(32'(kwidth_reg), MAX_K);
        int unsigned kh = clamp_dim(32'(kheight_reg), MAX_K);
        return !(kw > iw || kh > ih || col > iw - kw || row > ih - kh);
    endfunction

    // Updates the stores; returns 1 when the item yields a result.
    function automatic bit predict_convolution(input conv_item_t it, output conv_result_t res);
        longint acc;
        int unsigned kw, kh, cc, c, r, k;
        res = '0;
        acc = 0;
        case (it.op)
            mvc_pkg::OP_WRITE_KERNEL: begin
                if (it.row < MAX_K && it.col < MAX_K) begin
                    kernel_mem[it.channel][it.row][it.col] = it.value;
                    kernel_set[it.channel][it.row][it.col] = 1'b1;
                end
                return 1'b0;
            end
            mvc_pkg::OP_WRITE_IMAGE: begin
                image_mem[it.channel][it.row][it.col] = it.value;
                image_set[it.channel][it.row][it.col] = 1'b1;
                return 1'b0;
            end
            mvc_pkg::OP_COMPUTE: begin
                if (!in_valid_area(32'(it.row), 32'(it.col))) begin
                    res.status = 1'b1;
                    return 1'b1;
                end
                kw = clamp_dim(32'(kwidth_reg), MAX_K);
                kh = clamp_dim(32'(kheight_reg), MAX_K);
                cc = clamp_dim(32'(chan_reg), MAX_CH);
                for (c = 0; c < cc; c++)
                    for (r = 0; r < kh; r++)
                        for (k = 0; k < kw; k++)
                            acc += longint'(image_mem[c][it.row + r][it.col + k]) *
                                   longint'(kernel_mem[c][r][k]);
                if (acc > SUM_MAX) acc = SUM_MAX;
                if (acc < SUM_MIN) acc = SUM_MIN;
                res.conv_value = acc[mvc_pkg::OUT_W-1:0];
                return 1'b1;
            end
            default: return 1'b0;
        endcase
    endfunction

    task automatic report_mismatch(input string what, input logic [mvc_pkg::OUT_W-1:0] got,
                                   input logic [mvc_pkg::OUT_W-1:0] want);
        $display("mismatch at %0t: %s got %h expected %h", $realtime, what, got, want);
        error_count++;
    endtask

    task automatic send_item(input logic [mvc_pkg::OP_W-1:0] op, input int unsigned ch,
                             input int unsigned row, input int unsigned col,
                             input logic [mvc_pkg::VALUE_W-1:0] value);
        conv_item_t   it;
        conv_result_t res;
        it.op      = op;
        it.channel = ch[mvc_pkg::CHANNEL_W-1:0];
        it.row     = row[mvc_pkg::ROW_W-1:0];
        it.col     = col[mvc_pkg::COL_W-1:0];
        it.value   = value;
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tuser  <= it.op;
        s_tdata  <= mvc_pkg::S_TDATA_W'({it.value, it.col, it.row, it.channel});
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        if (predict_convolution(it, res)) begin
            pending_sums.push_back(res);
            compute_count++;
            if (res.status) oob_count++;
        end else if (op != OP_UNUSED) begin
            write_count++;
        end
        if (!(op == OP_UNUSED ||
              (op == mvc_pkg::OP_WRITE_KERNEL && (row >= MAX_K || col >= MAX_K))))
            counted_items++;
    endtask

    // Fills any unwritten entry the computation would read, then asks for it.
    task automatic compute_at(input int unsigned row, input int unsigned col);
        int unsigned kw, kh, cc, c, r, k;
        kw = clamp_dim(32'(kwidth_reg), MAX_K);
        kh = clamp_dim(32'(kheight_reg), MAX_K);
        cc = clamp_dim(32'(chan_reg), MAX_CH);
        if (in_valid_area(row, col)) begin
            for (c = 0; c < cc; c++)
                for (r = 0; r < kh; r++)
                    for (k = 0; k < kw; k++) begin
                        if (!image_set[c][row + r][col + k])
                            send_item(mvc_pkg::OP_WRITE_IMAGE, c, row + r, col + k,
                                      sample_t'($urandom));
                        if (!kernel_set[c][r][k])
                            send_item(mvc_pkg::OP_WRITE_KERNEL, c, r, k,
                                      sample_t'($urandom));
                    end
        end
        send_item(mvc_pkg::OP_COMPUTE, $urandom_range(3), row, col, sample_t'($urandom));
    endtask

    task automatic wait_results;
        if (pending_sums.size() != 0) begin
            s_tvalid <= 1'b0;
            do @(posedge aclk); while (pending_sums.size() != 0);
        end
    endtask

    task automatic settle;
        wait_results();
        s_tvalid <= 1'b0;
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic set_sizes(input logic [6:0] iw, input logic [6:0] ih, input logic [6:0] kw,
                             input logic [6:0] kh, input logic [6:0] cc);
        logic [mvc_pkg::CFG_ADDR_W-1:0] addrs [5] = '{mvc_pkg::CFG_IMAGE_WIDTH,
                                                      mvc_pkg::CFG_IMAGE_HEIGHT,
                                                      mvc_pkg::CFG_KERNEL_WIDTH,
                                                      mvc_pkg::CFG_KERNEL_HEIGHT,
                                                      mvc_pkg::CFG_CHANNEL_COUNT};
        logic [6:0] vals [5];
        vals = '{iw, ih, kw, kh, cc};
        for (int i = 0; i < 5; i++) begin
            cfg_addr  <= addrs[i];
            cfg_data  <= vals[i];
            cfg_valid <= 1'b1;
            @(posedge aclk);
            while (!cfg_ready) @(posedge aclk);
            case (addrs[i])
                mvc_pkg::CFG_IMAGE_WIDTH:   width_reg   = vals[i];
                mvc_pkg::CFG_IMAGE_HEIGHT:  height_reg  = vals[i];
                mvc_pkg::CFG_KERNEL_WIDTH:  kwidth_reg  = vals[i][3:0];
                mvc_pkg::CFG_KERNEL_HEIGHT: kheight_reg = vals[i][3:0];
                mvc_pkg::CFG_CHANNEL_COUNT: chan_reg    = vals[i][2:0];
                default: ;
            endcase
            cfg_count++;
        end
        cfg_valid <= 1'b0;
    endtask

    // default sizes: full-scale values, far-corner tap, ignored items, edge of valid area
    task automatic test_directed_extremes;
        send_item(mvc_pkg::OP_WRITE_IMAGE, 0, 61, 61, 16'h8000);
        send_item(mvc_pkg::OP_WRITE_KERNEL, 0, 0, 0, 16'h8000);
        send_item(mvc_pkg::OP_WRITE_IMAGE, 0, 63, 63, 16'h7fff);
        send_item(mvc_pkg::OP_WRITE_KERNEL, 0, 2, 2, 16'h7fff);
        send_item(mvc_pkg::OP_WRITE_IMAGE, 3, 63, 63, 16'h7fff);
        send_item(mvc_pkg::OP_WRITE_KERNEL, 2, 8, 0, 16'h1234);
        send_item(mvc_pkg::OP_WRITE_KERNEL, 1, 0, 63, 16'hffff);
        send_item(OP_UNUSED, 3, 63, 63, 16'hffff);
        compute_at(61, 61);
        compute_at(62, 0);
        compute_at(0, 62);
        compute_at(63, 63);
    endtask

    // size registers beyond their range saturate; kernel wider than image
    task automatic test_size_limits;
        settle();
        set_sizes(7'd0, 7'd127, 7'd0, 7'd127, 7'd0);
        compute_at(56, 0);
        compute_at(57, 0);
        compute_at(0, 1);
        settle();
        set_sizes(7'd2, 7'd2, 7'd5, 7'd1, 7'd127);
        compute_at(0, 0);
        compute_at(1, 1);
    endtask

    task automatic test_full_extent;
        settle();
        set_sizes(7'd64, 7'd64, 7'd8, 7'd8, 7'd4);
        compute_at(56, 56);
        compute_at(57, 56);
        compute_at(56, 57);
    endtask

    // long receiver hold-off fills the block; then a pause until all results drain
    task automatic test_backpressure;
        settle();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        set_sizes(7'd6, 7'd6, 7'd2, 7'd2, 7'd2);
        stall_request = 300;
        repeat (8) compute_at($urandom_range(4), $urandom_range(4));
        wait_results();
        repeat (4) compute_at($urandom_range(4), $urandom_range(4));
    endtask

    task automatic test_random_traffic(input int sp, input int rp, input int unsigned iw,
                                       input int unsigned ih, input int unsigned kw,
                                       input int unsigned kh, input int unsigned cc,
                                       input int n);
        int start;
        int unsigned pick, bound;
        settle();
        send_idle_pct = sp;
        recv_idle_pct = rp;
        set_sizes(iw[6:0], ih[6:0], kw[6:0], kh[6:0], cc[6:0]);
        start = counted_items;
        while (counted_items - start < n) begin
            pick = $urandom_range(99);
            if (pick < 50) begin
                if ($urandom_range(9) < 8)
                    compute_at($urandom_range(ih - kh), $urandom_range(iw - kw));
                else
                    compute_at($urandom_range(63), $urandom_range(63));
            end else if (pick < 75) begin
                if ($urandom_range(9) < 7)
                    send_item(mvc_pkg::OP_WRITE_IMAGE, $urandom_range(3),
                              $urandom_range(ih - 1), $urandom_range(iw - 1),
                              sample_t'($urandom));
                else
                    send_item(mvc_pkg::OP_WRITE_IMAGE, $urandom_range(3), $urandom_range(63),
                              $urandom_range(63), sample_t'($urandom));
            end else if (pick < 95) begin
                bound = ($urandom_range(9) == 0) ? 63 : MAX_K - 1;
                send_item(mvc_pkg::OP_WRITE_KERNEL, $urandom_range(3), $urandom_range(bound),
                          $urandom_range(bound), sample_t'($urandom));
            end else begin
                send_item(OP_UNUSED, $urandom_range(3), $urandom_range(63),
                          $urandom_range(63), sample_t'($urandom));
            end
        end
    endtask

    // result checker and receiver ready
    always @(posedge aclk) begin
        conv_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_sums.size() == 0) begin
                report_mismatch("unexpected result", m_tdata, '0);
            end else begin
                want = pending_sums.pop_front();
                if (m_tdata !== want.conv_value)
                    report_mismatch("conv_value", m_tdata, want.conv_value);
                if (m_tuser[0] !== want.status)
                    report_mismatch("status", out_word_t'(m_tuser[0]),
                                    out_word_t'(want.status));
            end
        end
        if (stall_request > 0) begin
            stall_left    = stall_request;
            stall_request = 0;
        end
        if (stall_left > 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("timeout: no transfer for %0d cycles", quiet_cycles);
                $display("[multichannel_valid_convolution] ERROR");
                $finish;
            end
        end
    end

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        test_directed_extremes();
        test_size_limits();
        test_full_extent();
        test_backpressure();
        test_random_traffic(14, 46, 8, 6, 3, 2, 2, 150);
        test_random_traffic(46, 14, 5, 9, 1, 4, 4, 150);
        test_random_traffic(0, 0, 12, 10, 4, 3, 3, 150);
        settle();
        $display("covered %0d items: %0d convolutions (%0d outside the valid area), %0d writes",
                 counted_items, compute_count, oob_count, write_count);
        $display("%0d register writes across default, saturated, full-size and small settings",
                 cfg_count);
        if (error_count == 0) begin
            $display("[multichannel_valid_convolution] OK");
        end else begin
            $display("[multichannel_valid_convolution] ERROR");
        end
        $finish;
    end

endmodule
